/* hw/rtl/oaht_pkg.sv */
package oaht_pkg;

  localparam int unsigned KEY_BITS = 32;
  localparam int unsigned DATA_BITS = 32;
  localparam int unsigned COUNT_BITS = 11;

  localparam logic [KEY_BITS-1:0] RESET_EMPTY_KEY = 32'hFFFF_FFFF;
  localparam logic [3:0] RESET_SIZE_LOG2 = 4'd10;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = 11'd2047;

  localparam logic [1:0] OP_GET = 2'd0;
  localparam logic [1:0] OP_PUT = 2'd1;
  localparam logic [1:0] OP_DEL = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic REG_SIZE_LOG2 = 1'b0;
  localparam logic REG_EMPTY_KEY = 1'b1;

  typedef struct packed {
    logic [1:0]           opcode;
    logic [KEY_BITS-1:0]  key;
    logic [DATA_BITS-1:0] value;
  } oaht_in_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [DATA_BITS-1:0]  read_value;
    logic [COUNT_BITS-1:0] entry_count;
  } oaht_out_t;

  typedef struct packed {
    logic       clear_step;
    logic       load;
    logic       set_st;
    logic [1:0] st_val;
    logic       cap_val;
    logic       write_slot;
    logic       write_empty;
    logic       count_inc;
    logic       count_dec;
    logic       swap;
    logic       advance;
    logic       start_scan;
    logic       out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] in_op;
    logic [1:0] cur_op;
    logic       in_key_empty;
    logic       hit;
    logic       slot_empty;
    logic       foreign;
    logic       probe_last;
    logic       round_last;
    logic       clear_last;
    logic       out_free;
  } dp_stat_t;

endpackage

/* hw/rtl/oaht_dp.sv */
module oaht_dp #(
  parameter int unsigned SLOTS_LOG2 = 10,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  oaht_pkg::dp_cmd_t  cmd,
  output oaht_pkg::dp_stat_t stat,
  input  oaht_pkg::oaht_in_t in_data,
  input  logic               cfg_valid,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_data,
  output logic               out_valid,
  input  logic               out_ready,
  output oaht_pkg::oaht_out_t out_data
);
  import oaht_pkg::*;

  localparam int unsigned SLOTS = 1 << SLOTS_LOG2;
  localparam logic [4:0] SL_MAX = 5'(SLOTS_LOG2);

  logic [KEY_BITS-1:0]   keys_mem [SLOTS];
  logic [VALUE_BITS-1:0] vals_mem [SLOTS];

  logic [3:0]            size_log2_r;
  logic [KEY_BITS-1:0]   empty_key_r;
  logic [1:0]            op_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [SLOTS_LOG2-1:0] addr_r;
  logic [SLOTS_LOG2-1:0] probe_cnt_r;
  logic [SLOTS_LOG2:0]   round_cnt_r;
  logic [KEY_BITS-1:0]   rd_key_r;
  logic [VALUE_BITS-1:0] rd_val_r;
  logic [1:0]            res_st_r;
  logic [DATA_BITS-1:0]  res_rd_r;
  logic [COUNT_BITS-1:0] count_r;
  logic                  out_valid_r;
  oaht_out_t             out_data_r;

  logic [4:0]            sl;
  logic [SLOTS_LOG2-1:0] mask;
  logic [SLOTS_LOG2:0]   n;
  logic [SLOTS_LOG2:0]   step_sum;
  logic [SLOTS_LOG2-1:0] next_addr;
  logic                  key_we;
  logic [KEY_BITS-1:0]   key_wd;

  always_comb begin
    priority if ({1'b0, size_log2_r} < 5'd1) begin
      sl = 5'd1;
    end else if ({1'b0, size_log2_r} > SL_MAX) begin
      sl = SL_MAX;
    end else begin
      sl = {1'b0, size_log2_r};
    end
  end

  assign mask = ~({SLOTS_LOG2{1'b1}} << sl);
  assign n = {1'b0, mask} + 1'b1;
  assign step_sum = {1'b0, addr_r} + (SLOTS_LOG2+1)'(3);
  assign next_addr = (step_sum >= n) ? '0 : step_sum[SLOTS_LOG2-1:0];

  assign stat.in_op = in_data.opcode;
  assign stat.cur_op = op_r;
  assign stat.in_key_empty = (in_data.key == empty_key_r);
  assign stat.hit = (rd_key_r == key_r);
  assign stat.slot_empty = (rd_key_r == empty_key_r);
  assign stat.foreign = ((rd_key_r[SLOTS_LOG2-1:0] & mask) != addr_r);
  assign stat.probe_last = (probe_cnt_r == mask);
  assign stat.round_last = (round_cnt_r == n);
  assign stat.clear_last = &addr_r;
  assign stat.out_free = !out_valid_r || out_ready;

  // config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_log2_r <= RESET_SIZE_LOG2;
      empty_key_r <= RESET_EMPTY_KEY;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SIZE_LOG2: size_log2_r <= cfg_data[3:0];
        REG_EMPTY_KEY: empty_key_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // probe address doubles as the clear sweep pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r <= '0;
    end else if (cmd.clear_step) begin
      addr_r <= addr_r + 1'b1;
    end else if (cmd.load) begin
      addr_r <= in_data.key[SLOTS_LOG2-1:0] & mask;
    end else if (cmd.swap) begin
      addr_r <= rd_key_r[SLOTS_LOG2-1:0] & mask;
    end else if (cmd.advance || cmd.start_scan) begin
      addr_r <= next_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r        <= in_data.opcode;
      key_r       <= in_data.key;
      val_r       <= VALUE_BITS'(in_data.value);
      probe_cnt_r <= '0;
      round_cnt_r <= '0;
      res_rd_r    <= '0;
    end else begin
      if (cmd.swap) begin
        key_r       <= rd_key_r;
        val_r       <= rd_val_r;
        round_cnt_r <= round_cnt_r + 1'b1;
      end
      if (cmd.start_scan) begin
        probe_cnt_r <= SLOTS_LOG2'(1);
      end else if (cmd.advance) begin
        probe_cnt_r <= probe_cnt_r + 1'b1;
      end
      if (cmd.cap_val && op_r == OP_GET) begin
        res_rd_r <= DATA_BITS'(rd_val_r);
      end
    end
    if (cmd.set_st) begin
      res_st_r <= cmd.st_val;
    end
  end

  assign key_we = cmd.clear_step || cmd.write_slot || cmd.write_empty;

  always_comb begin
    priority if (cmd.clear_step) begin
      key_wd = RESET_EMPTY_KEY;
    end else if (cmd.write_empty) begin
      key_wd = empty_key_r;
    end else begin
      key_wd = key_r;
    end
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      keys_mem[addr_r] <= key_wd;
    end
    rd_key_r <= keys_mem[addr_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.write_slot) begin
      vals_mem[addr_r] <= val_r;
    end
    rd_val_r <= vals_mem[addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.count_inc && count_r != COUNT_MAX) begin
      count_r <= count_r + 1'b1;
    end else if (cmd.count_dec && count_r != '0) begin
      count_r <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r.status      <= res_st_r;
      out_data_r.read_value  <= res_rd_r;
      out_data_r.entry_count <= count_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

`ifndef ASSERT_OFF
  a_one_key_write: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.clear_step, cmd.write_slot, cmd.write_empty}))
    else $error("conflicting key writes");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("result overwritten before taken");
  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!cmd.count_inc && !cmd.count_dec) |=> $stable(count_r))
    else $error("entry count moved without command");
`endif

endmodule

/* hw/rtl/oaht_ctrl.sv */
module oaht_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  oaht_pkg::dp_stat_t stat,
  output oaht_pkg::dp_cmd_t  cmd
);
  import oaht_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_PFIND, S_CFIND, S_PHOME, S_CHOME, S_PSCAN, S_CSCAN, S_DONE
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (stat.clear_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          cmd.set_st = 1'b1;
          cmd.st_val = ST_MISS;
          priority if (stat.in_key_empty) begin
            if (stat.in_op == OP_PUT) cmd.st_val = ST_FULL;
            state_nxt = S_DONE;
          end else if (stat.in_op == OP_GET || stat.in_op == OP_DEL) begin
            state_nxt = S_PFIND;
          end else if (stat.in_op == OP_PUT) begin
            state_nxt = S_PHOME;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_PFIND: state_nxt = S_CFIND;
      S_CFIND: begin
        priority if (stat.hit) begin
          cmd.set_st = 1'b1;
          cmd.st_val = ST_OK;
          cmd.cap_val = 1'b1;
          if (stat.cur_op == OP_DEL) begin
            cmd.write_empty = 1'b1;
            cmd.count_dec = 1'b1;
          end
          state_nxt = S_DONE;
        end else if (stat.probe_last) begin
          state_nxt = S_DONE;
        end else begin
          cmd.advance = 1'b1;
          state_nxt = S_PFIND;
        end
      end
      S_PHOME: state_nxt = S_CHOME;
      S_CHOME: begin
        priority if (stat.slot_empty) begin
          cmd.write_slot = 1'b1;
          cmd.count_inc = 1'b1;
          cmd.set_st = 1'b1;
          cmd.st_val = ST_OK;
          state_nxt = S_DONE;
        end else if (stat.foreign) begin
          cmd.write_slot = 1'b1;
          cmd.swap = 1'b1;
          if (stat.round_last) begin
            cmd.set_st = 1'b1;
            cmd.st_val = ST_FULL;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_PHOME;
          end
        end else begin
          cmd.start_scan = 1'b1;
          state_nxt = S_PSCAN;
        end
      end
      S_PSCAN: state_nxt = S_CSCAN;
      S_CSCAN: begin
        priority if (stat.slot_empty) begin
          cmd.write_slot = 1'b1;
          cmd.count_inc = 1'b1;
          cmd.set_st = 1'b1;
          cmd.st_val = ST_OK;
          state_nxt = S_DONE;
        end else if (stat.probe_last) begin
          cmd.set_st = 1'b1;
          cmd.st_val = ST_FULL;
          state_nxt = S_DONE;
        end else begin
          cmd.advance = 1'b1;
          state_nxt = S_PSCAN;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_adv_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.advance |-> !stat.probe_last)
    else $error("probe walked past one pass");
  a_swap_home: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.swap && !stat.round_last |=> state_r == S_PHOME)
    else $error("displaced entry not re-homed");
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> state_r != S_IDLE)
    else $error("accepted beat not processed");
`endif

endmodule

/* hw/rtl/open_addressing_hash_table.sv */
// Probing: a hit in the home slot ends the search there; a miss makes as many probes
//   as the configured size has slots, stepping by 3 and wrapping to slot 0.
// Requests are taken one at a time; a new request is taken
//   while the previous result still waits in the output register.
// Reset: synchronous, active low; then a clearing pass over all 2^SLOTS_LOG2 slots
//   (1024 by default) with in_ready low; config writes are taken throughout.
module open_addressing_hash_table #(
  parameter int unsigned SLOTS_LOG2 = 10,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  oaht_pkg::oaht_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output oaht_pkg::oaht_out_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [31:0]         cfg_data
);
  import oaht_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  oaht_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  oaht_dp #(
    .SLOTS_LOG2 (SLOTS_LOG2),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* tb/oaht_checker.sv */
`timescale 1ns / 100ps

module oaht_checker
  import oaht_pkg::*;
#(
  parameter int unsigned SLOTS_LOG2 = 10
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  oaht_in_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  oaht_out_t out_data,
  input  logic      cfg_valid,
  input  logic      cfg_ready,
  input  logic      cfg_index,
  input  logic [31:0] cfg_data,
  output int        mismatches,
  output int        awaited
);

  localparam int unsigned CAP = 1 << SLOTS_LOG2;

  logic [KEY_BITS-1:0]   slot_key [CAP];
  logic [DATA_BITS-1:0]  slot_val [CAP];
  logic [COUNT_BITS-1:0] stored;
  logic [3:0]            size_cfg;
  logic [KEY_BITS-1:0]   empty_cfg;

  oaht_out_t awaited_resp [$];
  oaht_out_t want;

  initial begin
    mismatches = 0;
    awaited = 0;
  end

  function automatic int unsigned probe_next(int unsigned idx, int unsigned n);
    return (idx + 3 >= n) ? 0 : idx + 3;
  endfunction

  // slot holding key, or n when the probe pass does not reach it
  function automatic int unsigned lookup(logic [KEY_BITS-1:0] key, int unsigned n);
    int unsigned idx;
    idx = key & (n - 1);
    for (int unsigned i = 0; i < n; i++) begin
      if (slot_key[idx] == key) return idx;
      idx = probe_next(idx, n);
    end
    return n;
  endfunction

  // displaces a foreign entry from the home slot and carries it on
  function automatic bit insert_entry(logic [KEY_BITS-1:0] key, logic [DATA_BITS-1:0] val,
                                      int unsigned n);
    int unsigned idx;
    logic [KEY_BITS-1:0] tk;
    logic [DATA_BITS-1:0] tv;
    for (int unsigned r = 0; r <= n; r++) begin
      idx = key & (n - 1);
      if (slot_key[idx] == empty_cfg) begin
        slot_key[idx] = key;
        slot_val[idx] = val;
        return 1'b1;
      end
      if ((slot_key[idx] & (n - 1)) != idx) begin
        tk = slot_key[idx];
        tv = slot_val[idx];
        slot_key[idx] = key;
        slot_val[idx] = val;
        key = tk;
        val = tv;
        continue;
      end
      idx = probe_next(idx, n);
      for (int unsigned i = 1; i < n; i++) begin
        if (slot_key[idx] == empty_cfg) begin
          slot_key[idx] = key;
          slot_val[idx] = val;
          return 1'b1;
        end
        idx = probe_next(idx, n);
      end
      return 1'b0;
    end
    return 1'b0;
  endfunction

  function automatic oaht_out_t table_access(oaht_in_t req);
    oaht_out_t res;
    logic [3:0] s;
    int unsigned n;
    int unsigned hit;
    s = size_cfg;
    if (s < 4'd1) s = 4'd1;
    if (s > SLOTS_LOG2) s = 4'(SLOTS_LOG2);
    n = 1 << s;
    res.status = ST_MISS;
    res.read_value = '0;
    case (req.opcode)
      OP_GET: begin
        if (req.key != empty_cfg) begin
          hit = lookup(req.key, n);
          if (hit < n) begin
            res.status = ST_OK;
            res.read_value = slot_val[hit];
          end
        end
      end
      OP_PUT: begin
        if (req.key == empty_cfg) begin
          res.status = ST_FULL;
        end else if (insert_entry(req.key, req.value, n)) begin
          res.status = ST_OK;
          if (stored != COUNT_MAX) stored++;
        end else begin
          res.status = ST_FULL;
        end
      end
      OP_DEL: begin
        if (req.key != empty_cfg) begin
          hit = lookup(req.key, n);
          if (hit < n) begin
            slot_key[hit] = empty_cfg;
            if (stored != 0) stored--;
            res.status = ST_OK;
          end
        end
      end
      default: ;
    endcase
    res.entry_count = stored;
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int unsigned i = 0; i < CAP; i++) begin
        slot_key[i] = RESET_EMPTY_KEY;
        slot_val[i] = '0;
      end
      stored = '0;
      size_cfg = RESET_SIZE_LOG2;
      empty_cfg = RESET_EMPTY_KEY;
      awaited_resp.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_SIZE_LOG2) size_cfg = cfg_data[3:0];
        else empty_cfg = cfg_data;
      end
      if (out_valid && out_ready) begin
        if (awaited_resp.size() == 0) begin
          $error("result beat with nothing awaited: status %0d read_value %h entry_count %0d",
                 out_data.status, out_data.read_value, out_data.entry_count);
          mismatches++;
        end else begin
          want = awaited_resp.pop_front();
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data.status);
            mismatches++;
          end
          if (out_data.read_value !== want.read_value) begin
            $error("read_value: expected %h, got %h", want.read_value, out_data.read_value);
            mismatches++;
          end
          if (out_data.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count,
                   out_data.entry_count);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) awaited_resp.push_back(table_access(in_data));
    end
    awaited <= awaited_resp.size();
  end

endmodule

/* tb/tb_open_addressing_hash_table.sv */
`timescale 1ns / 100ps

module tb_open_addressing_hash_table;
  import oaht_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned LONG_HOLD = 400;
  localparam int NUM_PHASES = 20;
  localparam int HOLD_PHASE = 6;
  localparam int EK_RESET = 0;
  localparam int EK_ZERO = 1;
  localparam int EK_RANDOM = 2;

  int unsigned ph_size [NUM_PHASES] =
    '{1, 2, 3, 4, 0, 5, 3, 15, 6, 2, 10, 4, 3, 7, 1, 5, 8, 2, 4, 3};
  int ph_empty [NUM_PHASES] =
    '{EK_RESET, EK_RESET, EK_RESET, EK_RESET, EK_ZERO, EK_ZERO, EK_RESET, EK_RESET,
      EK_RESET, EK_RANDOM, EK_RANDOM, EK_RANDOM, EK_RESET, EK_RESET, EK_ZERO, EK_RANDOM,
      EK_RESET, EK_RESET, EK_RESET, EK_RESET};
  int unsigned ph_items [NUM_PHASES] =
    '{80, 80, 80, 80, 70, 80, 120, 20, 80, 80, 30, 80, 80, 80, 70, 80, 50, 80, 110, 80};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  oaht_in_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  oaht_out_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = REG_SIZE_LOG2;
  logic [31:0] cfg_data = '0;

  int          mismatches;
  int          awaited;
  int unsigned idle_cycles = 0;
  bit          no_gaps = 1'b0;
  bit          long_hold = 1'b0;

  logic [KEY_BITS-1:0] cur_empty = RESET_EMPTY_KEY;
  logic [KEY_BITS-1:0] former_empty_q [$];
  logic [KEY_BITS-1:0] key_pool [$];

  always #2 clk = ~clk;

  open_addressing_hash_table DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  oaht_checker #(.SLOTS_LOG2(10)) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .awaited    (awaited)
  );

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // a get may not reach a slot whose value was never written: such slots only
  // carry keys that once served as the empty marker, so those gets become deletes
  task automatic send_req(input logic [1:0] op, input logic [KEY_BITS-1:0] key,
                          input logic [DATA_BITS-1:0] val);
    int unsigned gap;
    if (op == OP_GET && key != cur_empty) begin
      foreach (former_empty_q[i]) if (former_empty_q[i] == key) op = OP_DEL;
    end
    in_data <= {op, key, val};
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    gap = no_gaps ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] data);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // receiver: random stalls, ready stretches, and one long hold-off on request
  initial begin
    int unsigned len;
    forever begin
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold = 1'b0;
      end else if ($urandom_range(0, 99) < 35) begin
        out_ready <= 1'b0;
        len = pick_gap();
        if (len == 0) len = 1;
        repeat (len) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("** open_addressing_hash_table: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [KEY_BITS-1:0]  new_empty;
    logic [KEY_BITS-1:0]  key;
    logic [DATA_BITS-1:0] val;
    logic [31:0]          cfg_word;
    logic [1:0]           op;
    int unsigned          eff_log2;
    int unsigned          pool_n;
    int unsigned          r;

    former_empty_q.push_back(RESET_EMPTY_KEY);
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: empty table, empty-key requests, collisions, displacement,
    // delete without tombstone, unused opcode, duplicate put
    send_req(OP_GET, 32'h0000_0000, 32'h1234_5678);
    send_req(OP_PUT, 32'h0000_0000, 32'h0000_0000);
    send_req(OP_PUT, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
    send_req(OP_GET, 32'h0000_0000, 32'hFFFF_FFFF);
    send_req(OP_GET, 32'hFFFF_FFFE, 32'h0000_0000);
    send_req(OP_PUT, RESET_EMPTY_KEY, 32'hA5A5_A5A5);
    send_req(OP_GET, RESET_EMPTY_KEY, 32'h0000_0000);
    send_req(OP_DEL, RESET_EMPTY_KEY, 32'h0000_0000);
    send_req(OP_PUT, 32'h0000_0400, 32'h1111_1111);
    send_req(OP_PUT, 32'h0000_0003, 32'h2222_2222);
    send_req(OP_GET, 32'h0000_0400, 32'h0000_0000);
    send_req(OP_GET, 32'h0000_0003, 32'h0000_0000);
    send_req(OP_DEL, 32'h0000_0000, 32'h0000_0000);
    send_req(OP_GET, 32'h0000_0400, 32'h0000_0000);
    send_req(OP_DEL, 32'h0000_0000, 32'h0000_0000);
    send_req(OP_UNUSED, 32'h0000_0003, 32'h5555_5555);
    send_req(OP_PUT, 32'h0000_0003, 32'h3333_3333);
    send_req(OP_GET, 32'h0000_0003, 32'h0000_0000);
    send_req(OP_DEL, 32'h0000_0003, 32'h0000_0000);
    send_req(OP_GET, 32'h0000_0003, 32'h0000_0000);
    send_req(OP_PUT, 32'h7FFF_FC00, 32'h8000_0000);
    send_req(OP_GET, 32'h7FFF_FC00, 32'h0000_0000);

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      if (ph_empty[p] == EK_RESET) new_empty = RESET_EMPTY_KEY;
      else if (ph_empty[p] == EK_ZERO) new_empty = '0;
      else new_empty = $urandom;
      cfg_word = $urandom;
      cfg_word[3:0] = 4'(ph_size[p]);
      write_reg(REG_SIZE_LOG2, cfg_word);
      write_reg(REG_EMPTY_KEY, new_empty);
      cfg_valid <= 1'b0;
      cur_empty = new_empty;
      former_empty_q.push_back(new_empty);

      eff_log2 = ph_size[p];
      if (eff_log2 < 1) eff_log2 = 1;
      if (eff_log2 > 10) eff_log2 = 10;
      pool_n = (2 << eff_log2) + 2;
      if (pool_n > 24) pool_n = 24;
      key_pool.delete();
      repeat (pool_n) key_pool.push_back($urandom);

      no_gaps = (p % 5 == 3) || (p == HOLD_PHASE);
      if (p == HOLD_PHASE) long_hold = 1'b1;

      repeat (ph_items[p]) begin
        r = $urandom_range(0, 99);
        if (r < 42) op = OP_PUT;
        else if (r < 72) op = OP_GET;
        else if (r < 95) op = OP_DEL;
        else op = OP_UNUSED;
        r = $urandom_range(0, 99);
        if (r < 75) key = key_pool[$urandom_range(0, key_pool.size() - 1)];
        else if (r < 80) key = cur_empty;
        else if (r < 90) key = former_empty_q[$urandom_range(0, former_empty_q.size() - 1)];
        else key = $urandom;
        r = $urandom_range(0, 9);
        if (r == 0) val = '0;
        else if (r == 1) val = '1;
        else val = $urandom;
        send_req(op, key, val);
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("** open_addressing_hash_table: PASSED **");
    end else begin
      $display("** open_addressing_hash_table: FAILED **");
    end
    $finish;
  end

endmodule
